// ----- rtl/cfp_pkg.sv -----
`timescale 1ns / 1ps

package cfp_pkg;

	localparam int ByteW      = 8;
	localparam int TimeW      = 16;
	localparam int OutDataW   = 40;
	localparam int ReplyLen   = 6;
	localparam int BeatW      = 3;
	localparam int FifoDepth  = 2;
	localparam int PtrW       = 1;
	localparam int CountW     = 2;

	localparam logic [ByteW-1:0] RxHeaderRst = 8'h0B;
	localparam logic [ByteW-1:0] TxHeaderRst = 8'h0C;

	// register indexes on the configuration port
	localparam logic [0:0] RegRxHeader = 1'b0;
	localparam logic [0:0] RegTxHeader = 1'b1;

	// reply beat codes
	localparam logic [BeatW-1:0] BeatHdr   = 3'd0;
	localparam logic [BeatW-1:0] BeatOnLo  = 3'd1;
	localparam logic [BeatW-1:0] BeatOnHi  = 3'd2;
	localparam logic [BeatW-1:0] BeatOffLo = 3'd3;
	localparam logic [BeatW-1:0] BeatOffHi = 3'd4;
	localparam logic [BeatW-1:0] BeatSum   = 3'd5;

	// one decoded frame, ready to be replied
	typedef struct packed {
		logic [ByteW-1:0] hdr;
		logic [TimeW-1:0] on_time;
		logic [TimeW-1:0] off_time;
		logic [ByteW-1:0] sum;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

endpackage

// ----- rtl/cfp_parser.sv -----
`timescale 1ns / 1ps

module cfp_parser
	import cfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic [ByteW-1:0] rx_byte,
	input  logic [ByteW-1:0] rx_header,
	input  logic [ByteW-1:0] tx_header,
	output push_t            push
);

	localparam logic [1:0] PhHunt = 2'd0;
	localparam logic [1:0] PhHigh = 2'd1;
	localparam logic [1:0] PhLow  = 2'd2;
	localparam logic [1:0] PhSum  = 2'd3;

	logic [1:0]       phase_q;
	logic             idx_q;
	logic [TimeW-1:0] high_q;
	logic [TimeW-1:0] low_q;
	logic [ByteW-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHunt;
			idx_q   <= 1'b0;
			high_q  <= '0;
			low_q   <= '0;
			sum_q   <= '0;
		end else if (byte_valid) begin
			unique case (phase_q)
				PhHunt: begin
					if (rx_byte == rx_header) begin
						phase_q <= PhHigh;
						idx_q   <= 1'b0;
						sum_q   <= rx_header;
					end
				end
				PhHigh: begin
					if (idx_q) high_q[15:8] <= rx_byte;
					else       high_q[7:0]  <= rx_byte;
					sum_q <= sum_q + rx_byte;
					if (idx_q) phase_q <= PhLow;
					idx_q <= ~idx_q;
				end
				PhLow: begin
					if (idx_q) low_q[15:8] <= rx_byte;
					else       low_q[7:0]  <= rx_byte;
					sum_q <= sum_q + rx_byte;
					if (idx_q) phase_q <= PhSum;
					idx_q <= ~idx_q;
				end
				default: begin
					phase_q <= PhHunt;
				end
			endcase
		end
	end

	// push a frame when the checksum byte matches
	always_comb begin
		push.valid          = byte_valid && (phase_q == PhSum) && (rx_byte == sum_q);
		push.frame.hdr      = tx_header;
		push.frame.on_time  = high_q;
		push.frame.off_time = low_q;
		push.frame.sum      = tx_header + high_q[7:0] + high_q[15:8]
		                      + low_q[7:0] + low_q[15:8];
	end

endmodule

// ----- rtl/checksummed_frame_parser_echo.sv -----
`timescale 1ns / 1ps
// Checksummed frame parser with echo reply.
// Slave stream (s_*): one received byte per request in s_tdata[7:0]. The
// parser hunts for the rx_header byte, gathers on-time and off-time (low byte
// first) and checks the additive checksum; a bad frame is dropped silently.
// Master stream (m_*): six requests per good frame: tx_header, on-time low,
// on-time high, off-time low, off-time high, checksum; m_tlast on the sixth.
// Each beat also carries the decoded on-time and off-time.
// One input byte per cycle is taken while the queue has room; one reply beat per
// cycle goes out while a frame is queued and m_tready is high. From an empty
// queue, a frame's first reply beat is valid the cycle after its checksum byte is
// accepted. Decoded frames wait in a two-entry frame queue, which sets s_tready:
// input is held off only while both entries are occupied. Configuration: cfg_we
// with cfg_index 0 writes rx_header, 1 writes tx_header; write only while idle.
// Reset: parser returns to hunting, the queue empties, headers take 0x0B and
// 0x0C. When the receiver stalls, the current beat holds until taken.
module checksummed_frame_parser_echo
	import cfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteW-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [7:0] tx_byte, [23:8] on_time, [39:24] off_time
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [ByteW-1:0]    cfg_data
);

	logic [ByteW-1:0] rx_header_q;
	logic [ByteW-1:0] tx_header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_header_q <= RxHeaderRst;
			tx_header_q <= TxHeaderRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRxHeader: rx_header_q <= cfg_data;
				default:     tx_header_q <= cfg_data;
			endcase
		end
	end

	logic  in_acc;
	push_t push;

	assign in_acc = s_tvalid && s_tready;

	cfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_acc),
		.rx_byte    (s_tdata),
		.rx_header  (rx_header_q),
		.tx_header  (tx_header_q),
		.push       (push)
	);

	// frame queue
	frame_t           fifo_q [FifoDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CountW-1:0] count_q;
	logic [BeatW-1:0] beat_q;
	logic             out_acc;
	logic             pop;
	frame_t           head;

	assign s_tready = (count_q != CountW'(FifoDepth));
	assign m_tvalid = (count_q != '0);
	assign out_acc  = m_tvalid && m_tready;
	assign pop      = out_acc && (beat_q == BeatSum);
	assign head     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) fifo_q[wr_ptr_q] <= push.frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			beat_q   <= BeatHdr;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)        rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			// advance through the six reply beats, wrap after the checksum
			if (out_acc) beat_q <= pop ? BeatHdr : beat_q + 1'b1;
		end
	end

	logic [ByteW-1:0] tx_byte;

	always_comb begin
		unique case (beat_q)
			BeatHdr:   tx_byte = head.hdr;
			BeatOnLo:  tx_byte = head.on_time[7:0];
			BeatOnHi:  tx_byte = head.on_time[15:8];
			BeatOffLo: tx_byte = head.off_time[7:0];
			BeatOffHi: tx_byte = head.off_time[15:8];
			default:   tx_byte = head.sum;
		endcase
	end

	assign m_tdata = {head.off_time, head.on_time, tx_byte};
	assign m_tlast = (beat_q == BeatSum);

endmodule

// ----- rtl/cfp_checker.sv -----
`timescale 1ns / 1ps

module cfp_checker
	import cfp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                m_tlast
);

	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("reply valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("reply valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("reply beat changed while stalled");

	a_frame_times: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[39:8] == $past(m_tdata[39:8])))
		else $error("decoded times changed inside a reply");

endmodule

bind checksummed_frame_parser_echo cfp_checker u_cfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// Frame parser testbench: bytes go in on the slave stream, a local decoder
// follows the same hunt / gather / checksum rules and queues the six reply
// requests that a good frame must produce; each reply request taken from the
// master stream is compared against the head of that queue.
module tb;
	import cfp_pkg::*;

	localparam int CycleLimit  = 300000;
	localparam int RandomItems = 370;
	localparam int SettleCycles = 4;

	// decoder states, in the order the bytes of a frame arrive
	typedef enum logic [1:0] {
		SeekHdr,
		GetOn,
		GetOff,
		GetSum
	} parse_state_e;

	typedef struct {
		logic [ByteW-1:0] tx_byte;
		logic             last;
		logic [TimeW-1:0] on_time;
		logic [TimeW-1:0] off_time;
	} reply_beat_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [ByteW-1:0]    s_tdata;   // [7:0] rx_byte
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;   // [7:0] tx_byte, [23:8] on_time, [39:24] off_time
	logic                m_tlast;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [ByteW-1:0]    cfg_data;

	// decoder copy of the registers and the parse state
	logic [ByteW-1:0] rx_hdr;
	logic [ByteW-1:0] tx_hdr;
	parse_state_e     pstate;
	logic             half;
	logic [TimeW-1:0] on_acc;
	logic [TimeW-1:0] off_acc;
	logic [ByteW-1:0] csum;

	reply_beat_t reply_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          burst_left = 0;
	int          gap_max = 6;

	logic [6:0]  ready_phase = '0;
	logic [15:0] ready_pat = '1;

	checksummed_frame_parser_echo uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: walk a 16-bit ready pattern, draw a fresh one whenever the
	// 7-bit phase counter wraps; a quarter of the windows are fully ready.
	// Never all zero, so each pass through the pattern has a ready cycle.
	always @(posedge clk) begin
		ready_phase <= ready_phase + 7'd1;
		if (ready_phase == '0) begin
			ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end
		m_tready <= ready_pat[ready_phase[3:0]];
	end

	// Guard against a hung block or a lost reply request.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("checksummed_frame_parser_echo: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
			input logic [TimeW-1:0] want);
		$display("%0t %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Compare every reply request taken by the receiver with the oldest
	// expectation; values sampled here are those from before the edge.
	always @(posedge clk) begin
		reply_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_q.size() == 0) begin
				report_mismatch("reply with nothing expected, tx_byte",
					TimeW'(m_tdata[7:0]), '0);
			end else begin
				want = reply_q.pop_front();
				if (m_tdata[7:0] !== want.tx_byte)
					report_mismatch("tx_byte", TimeW'(m_tdata[7:0]), TimeW'(want.tx_byte));
				if (m_tlast !== want.last)
					report_mismatch("last", TimeW'(m_tlast), TimeW'(want.last));
				if (m_tdata[23:8] !== want.on_time)
					report_mismatch("on_time", m_tdata[23:8], want.on_time);
				if (m_tdata[39:24] !== want.off_time)
					report_mismatch("off_time", m_tdata[39:24], want.off_time);
			end
		end
	end

	// Queue the six requests of the echo reply for the frame just closed.
	task automatic queue_echo();
		logic [ByteW-1:0] beat [ReplyLen];
		beat[BeatHdr]   = tx_hdr;
		beat[BeatOnLo]  = on_acc[7:0];
		beat[BeatOnHi]  = on_acc[15:8];
		beat[BeatOffLo] = off_acc[7:0];
		beat[BeatOffHi] = off_acc[15:8];
		beat[BeatSum]   = beat[BeatHdr] + beat[BeatOnLo] + beat[BeatOnHi]
			+ beat[BeatOffLo] + beat[BeatOffHi];
		for (int k = 0; k < ReplyLen; k++) begin
			reply_q.push_back('{beat[k], (k == ReplyLen - 1), on_acc, off_acc});
		end
	endtask

	// Decode one accepted byte. A header value inside a frame is plain data,
	// and the checksum keeps whatever header opened the frame.
	task automatic parse_byte(input logic [ByteW-1:0] b);
		case (pstate)
			SeekHdr: begin
				if (b == rx_hdr) begin
					pstate = GetOn;
					half = 1'b0;
					csum = rx_hdr;
				end
			end
			GetOn: begin
				if (half) on_acc[15:8] = b;
				else on_acc[7:0] = b;
				csum = csum + b;
				if (half) pstate = GetOff;
				half = ~half;
			end
			GetOff: begin
				if (half) off_acc[15:8] = b;
				else off_acc[7:0] = b;
				csum = csum + b;
				if (half) pstate = GetSum;
				half = ~half;
			end
			default: begin
				pstate = SeekHdr;
				if (b == csum) queue_echo();
			end
		endcase
	endtask

	// Offer one byte; bursts of random length with random gaps between them.
	task automatic send_byte(input logic [ByteW-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		parse_byte(b);
	endtask

	// Hold the sender until every expected reply request has come, then let
	// the pipeline settle.
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [ByteW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == RegRxHeader) rx_hdr = val;
		else tx_hdr = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Send a whole frame under the current rx header; corrupt the checksum
	// when asked.
	task automatic send_frame(input logic [TimeW-1:0] on_t, input logic [TimeW-1:0] off_t,
			input bit bad);
		logic [ByteW-1:0] hdr;
		logic [ByteW-1:0] sum;
		hdr = rx_hdr;
		sum = hdr + on_t[7:0] + on_t[15:8] + off_t[7:0] + off_t[15:8];
		if (bad) sum = sum + 8'($urandom_range(1, 255));
		send_byte(hdr);
		send_byte(on_t[7:0]);
		send_byte(on_t[15:8]);
		send_byte(off_t[7:0]);
		send_byte(off_t[15:8]);
		send_byte(sum);
	endtask

	// Bias time values towards the extremes and the header value itself.
	function automatic logic [TimeW-1:0] pick_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {rx_hdr, rx_hdr};
			default: return TimeW'($urandom);
		endcase
	endfunction

	// Reset headers: stray bytes while hunting, then a frame with extreme times.
	task automatic test_default_headers();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(16'h0000, 16'hFFFF, 1'b0);
		drain_replies();
	endtask

	// A bad checksum drops the frame without any reply.
	task automatic test_bad_checksum();
		send_frame(TimeW'($urandom), TimeW'($urandom), 1'b1);
		drain_replies();
	endtask

	// Extreme header settings, with the header value appearing as data.
	task automatic test_header_extremes();
		write_reg(RegRxHeader, 8'hFF);
		write_reg(RegTxHeader, 8'h00);
		send_frame(16'hFFFF, 16'h00FF, 1'b0);
		drain_replies();
	endtask

	// Rewrite both headers while a frame is half gathered: the new tx header
	// goes into the reply, while the checksum still holds the old rx header.
	task automatic test_mid_frame_rewrite();
		logic [ByteW-1:0] sum;
		write_reg(RegRxHeader, 8'h00);
		write_reg(RegTxHeader, 8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		drain_replies();
		write_reg(RegRxHeader, 8'h5A);
		write_reg(RegTxHeader, 8'h33);
		sum = 8'h00 + 8'h5A + 8'hA5 + 8'h3C + 8'hC3;
		send_byte(8'hA5);
		send_byte(8'h3C);
		send_byte(8'hC3);
		send_byte(sum);
		drain_replies();
	endtask

	// Mostly well-formed frames with random content; the rest is stray
	// bytes, bad checksums and cut-off frames. Four header settings, one of
	// them with back-to-back requests.
	task automatic test_random_frames();
		int sent;
		int frames;
		int r;
		int n;
		logic [ByteW-1:0] b;
		sent = 0;
		frames = 0;
		for (int s = 0; s < 4; s++) begin
			drain_replies();
			write_reg(RegRxHeader, ByteW'($urandom));
			write_reg(RegTxHeader, ByteW'($urandom));
			gap_max = (s == 1) ? 0 : 6;
			while (sent < (s + 1) * RandomItems / 4) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					n = $urandom_range(1, 4);
					repeat (n) begin
						do b = ByteW'($urandom); while (b == rx_hdr);
						send_byte(b);
					end
				end else if (r < 20) begin
					send_frame(pick_time(), pick_time(), 1'b1);
					sent += ReplyLen;
				end else if (r < 26) begin
					n = $urandom_range(1, 4);
					send_byte(rx_hdr);
					repeat (n) send_byte(ByteW'($urandom));
					sent += n + 1;
				end else begin
					send_frame(pick_time(), pick_time(), 1'b0);
					sent += ReplyLen;
				end
				frames++;
				// hold off now and then until the reply queue is empty
				if (frames % 9 == 0) drain_replies();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = RegRxHeader;
		cfg_data = '0;
		rx_hdr = RxHeaderRst;
		tx_hdr = TxHeaderRst;
		pstate = SeekHdr;
		half = 1'b0;
		on_acc = '0;
		off_acc = '0;
		csum = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_headers();
		test_bad_checksum();
		test_header_extremes();
		test_mid_frame_rewrite();
		test_random_frames();
		drain_replies();

		if (mismatches == 0) begin
			$display("checksummed_frame_parser_echo: match");
		end else begin
			$display("checksummed_frame_parser_echo: mismatch");
		end
		$finish;
	end

endmodule
